// ===== src/assert_macros.svh =====
// Assertion macros shared by the RMS power meter RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// expression must hold at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
// same-cycle implication
`define ASSERT_IMPLIES(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`endif

// ===== src/rpm_pkg.sv =====
// Shared constants for the RMS power meter
package rpm_pkg;
    localparam int MAX_WINDOW = 4096;
    localparam int IDX_W      = $clog2(MAX_WINDOW + 1);
    localparam logic [IDX_W-1:0] MAX_WIN_N = IDX_W'(MAX_WINDOW);

    localparam int ADC_FULL_SHIFT = 15;  // full scale is 2^15 - 1

    localparam int MUL_W      = 64;
    localparam int DIV_NUM_W  = 96;
    localparam int DIV_DEN_W  = 55;
    localparam int DIV_Q_W    = 48;
    localparam int SQRT_IN_W  = 56;
    localparam int SQRT_OUT_W = 28;

    localparam logic [47:0] POW_POS_MAX = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] POW_NEG_MAX = 48'h8000_0000_0000;

    localparam logic [2:0] REG_WINDOW    = 3'd0;
    localparam logic [2:0] REG_CUR_SCALE = 3'd1;
    localparam logic [2:0] REG_VOL_SCALE = 3'd2;
    localparam logic [2:0] REG_FRACTION  = 3'd3;
    localparam logic [2:0] REG_FLOOR     = 3'd4;
endpackage

// ===== src/rms_power_meter_with_stability.sv =====
// A pair not ending a frame goes through S_SQ_II, S_SQ_VV and S_SQ_IV inside the window
// and is dropped in S_IDLE past it. A frame-end pair runs twelve shift-add multiplies,
// two square roots and three divides, then S_EMIT loads the output registers when free.
// A new pair is accepted only in S_IDLE; in_stall is high while busy.
// Reset: async active low; sums, count and previous RMS clear, registers take defaults.
module rms_power_meter_with_stability (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic signed [15:0]  current_sample,
    input  logic signed [15:0]  voltage_sample,
    input  logic                frame_end,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [31:0]         current_rms,
    output logic [31:0]         voltage_rms,
    output logic signed [47:0]  active_power,
    output logic                stable,
    input  logic                cfg_write,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data
);
    import rpm_pkg::*;
    `include "assert_macros.svh"

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_SQ_II = 5'd1;
    localparam logic [4:0] S_SQ_VV = 5'd2;
    localparam logic [4:0] S_SQ_IV = 5'd3;
    localparam logic [4:0] S_NS_GO = 5'd4;
    localparam logic [4:0] S_NS_W  = 5'd5;
    localparam logic [4:0] S_S2_W  = 5'd6;
    localparam logic [4:0] S_RT_GO = 5'd7;
    localparam logic [4:0] S_RT_W  = 5'd8;
    localparam logic [4:0] S_RN_W  = 5'd9;
    localparam logic [4:0] S_RD_W  = 5'd10;
    localparam logic [4:0] S_PA_GO = 5'd11;
    localparam logic [4:0] S_PA_W  = 5'd12;
    localparam logic [4:0] S_PB_W  = 5'd13;
    localparam logic [4:0] S_PC_W  = 5'd14;
    localparam logic [4:0] S_PD_W  = 5'd15;
    localparam logic [4:0] S_PP_W  = 5'd16;
    localparam logic [4:0] S_PQ_W  = 5'd17;
    localparam logic [4:0] S_TH_W  = 5'd18;
    localparam logic [4:0] S_EMIT  = 5'd19;

    logic [4:0]        state_reg, state_next;
    logic              ch_reg, ch_next;
    logic [15:0]       ci_reg, ci_next;
    logic [15:0]       vi_reg, vi_next;
    logic              fe_reg, fe_next;

    logic [IDX_W-1:0]  window_reg, window_next;
    logic [31:0]       cscale_reg, cscale_next;
    logic [31:0]       vscale_reg, vscale_next;
    logic [15:0]       frac_reg, frac_next;
    logic [31:0]       floor_reg, floor_next;

    logic [28:0]       si_reg, si_next;
    logic [28:0]       sv_reg, sv_next;
    logic [42:0]       sii_reg, sii_next;
    logic [42:0]       svv_reg, svv_next;
    logic [43:0]       siv_reg, siv_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [31:0]       prev_rms_reg, prev_rms_next;

    logic [55:0]       ns_reg, ns_next;
    logic [55:0]       s2_reg, s2_next;
    logic [31:0]       irms_reg, irms_next;
    logic [31:0]       vrms_reg, vrms_next;
    logic [55:0]       pa_reg, pa_next;
    logic [55:0]       pb_reg, pb_next;
    logic [63:0]       cv_reg, cv_next;
    logic [54:0]       nd_reg, nd_next;
    logic [47:0]       mag_reg, mag_next;
    logic              neg_reg, neg_next;
    logic              stable_reg, stable_next;

    logic              out_valid_reg, out_valid_next;
    logic [31:0]       out_irms_reg, out_irms_next;
    logic [31:0]       out_vrms_reg, out_vrms_next;
    logic [47:0]       out_pw_reg, out_pw_next;
    logic              out_stable_reg, out_stable_next;

    logic                  mul_start, mul_done;
    logic [MUL_W-1:0]      mul_a, mul_b;
    logic [2*MUL_W-1:0]    mul_p;
    logic                  div_start, div_done, div_ovf;
    logic [DIV_NUM_W-1:0]  div_num;
    logic [DIV_DEN_W-1:0]  div_den;
    logic [DIV_Q_W-1:0]    div_q;
    logic                  sqrt_start, sqrt_done;
    logic [SQRT_OUT_W-1:0] sqrt_root;

    logic [IDX_W-1:0]  win;
    logic              take;
    logic              in_acc;
    logic [15:0]       sm_a, sm_b;
    logic signed [31:0] sm_p;
    logic [28:0]       si_neg, sv_neg;
    logic [27:0]       si_abs, sv_abs, sum_abs_sel;
    logic [43:0]       siv_neg;
    logic [42:0]       siv_abs;
    logic [42:0]       sq_sel;
    logic [31:0]       scale_sel;
    logic [27:0]       n_adc;
    logic [55:0]       var_d;
    logic [59:0]       t1, t2, e_val, e_abs;
    logic              e_neg;
    logic [31:0]       rms_val;
    logic [47:0]       lim;
    logic [47:0]       mag_val;
    logic [47:0]       thr, thr_eff;
    logic [31:0]       rms_diff;

    rpm_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .p     (mul_p)
    );

    rpm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .q     (div_q),
        .ovf   (div_ovf)
    );

    rpm_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start),
        .x     (var_d),
        .done  (sqrt_done),
        .root  (sqrt_root)
    );

    assign in_stall = (state_reg != S_IDLE);
    assign in_acc   = in_valid && !in_stall;

    always_comb
    begin
        if (window_reg == '0)
            win = IDX_W'(1);
        else if (window_reg > MAX_WIN_N)
            win = MAX_WIN_N;
        else
            win = window_reg;
    end
    assign take = idx_reg < win;

    assign sm_a = (state_reg == S_SQ_VV) ? vi_reg : ci_reg;
    assign sm_b = (state_reg == S_SQ_II) ? ci_reg : vi_reg;
    assign sm_p = $signed(sm_a) * $signed(sm_b);

    assign si_neg      = 29'd0 - si_reg;
    assign sv_neg      = 29'd0 - sv_reg;
    assign si_abs      = si_reg[28] ? si_neg[27:0] : si_reg[27:0];
    assign sv_abs      = sv_reg[28] ? sv_neg[27:0] : sv_reg[27:0];
    assign siv_neg     = 44'd0 - siv_reg;
    assign siv_abs     = siv_reg[43] ? siv_neg[42:0] : siv_reg[42:0];
    assign sum_abs_sel = ch_reg ? sv_abs : si_abs;
    assign sq_sel      = ch_reg ? svv_reg : sii_reg;
    assign scale_sel   = ch_reg ? vscale_reg : cscale_reg;

    // n * (2^15 - 1)
    assign n_adc = {idx_reg, {ADC_FULL_SHIFT{1'b0}}} - {{ADC_FULL_SHIFT{1'b0}}, idx_reg};
    assign var_d = (ns_reg > s2_reg) ? (ns_reg - s2_reg) : '0;

    // E = n*Siv - Si*Sv
    assign t1    = siv_reg[43] ? (60'd0 - {4'd0, pa_reg}) : {4'd0, pa_reg};
    assign t2    = (si_reg[28] ^ sv_reg[28]) ? (60'd0 - {4'd0, pb_reg}) : {4'd0, pb_reg};
    assign e_val = t1 - t2;
    assign e_neg = e_val[59];
    assign e_abs = e_neg ? (60'd0 - e_val) : e_val;

    assign rms_val = (div_ovf || (div_q[47:32] != '0)) ? '1 : div_q[31:0];
    assign lim     = e_neg ? POW_NEG_MAX : POW_POS_MAX;
    assign mag_val = (div_ovf || (div_q > lim)) ? lim : div_q;

    assign thr      = mul_p[63:16];
    assign thr_eff  = (thr < {16'd0, floor_reg}) ? {16'd0, floor_reg} : thr;
    assign rms_diff = (prev_rms_reg > irms_reg) ? (prev_rms_reg - irms_reg)
                                                : (irms_reg - prev_rms_reg);

    always_comb
    begin
        state_next      = state_reg;
        ch_next         = ch_reg;
        ci_next         = ci_reg;
        vi_next         = vi_reg;
        fe_next         = fe_reg;
        window_next     = window_reg;
        cscale_next     = cscale_reg;
        vscale_next     = vscale_reg;
        frac_next       = frac_reg;
        floor_next      = floor_reg;
        si_next         = si_reg;
        sv_next         = sv_reg;
        sii_next        = sii_reg;
        svv_next        = svv_reg;
        siv_next        = siv_reg;
        idx_next        = idx_reg;
        prev_rms_next   = prev_rms_reg;
        ns_next         = ns_reg;
        s2_next         = s2_reg;
        irms_next       = irms_reg;
        vrms_next       = vrms_reg;
        pa_next         = pa_reg;
        pb_next         = pb_reg;
        cv_next         = cv_reg;
        nd_next         = nd_reg;
        mag_next        = mag_reg;
        neg_next        = neg_reg;
        stable_next     = stable_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_irms_next   = out_irms_reg;
        out_vrms_next   = out_vrms_reg;
        out_pw_next     = out_pw_reg;
        out_stable_next = out_stable_reg;
        mul_start       = 1'b0;
        mul_a           = '0;
        mul_b           = '0;
        div_start       = 1'b0;
        div_num         = '0;
        div_den         = '0;
        sqrt_start      = 1'b0;

        if (cfg_write)
        begin
            case (cfg_index)
                REG_WINDOW:    window_next = cfg_data[IDX_W-1:0];
                REG_CUR_SCALE: cscale_next = cfg_data;
                REG_VOL_SCALE: vscale_next = cfg_data;
                REG_FRACTION:  frac_next   = cfg_data[15:0];
                REG_FLOOR:     floor_next  = cfg_data;
                default:       ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    ci_next = current_sample;
                    vi_next = voltage_sample;
                    fe_next = frame_end;
                    ch_next = 1'b0;
                    if (take)
                    begin
                        si_next    = si_reg + {{13{current_sample[15]}}, current_sample};
                        sv_next    = sv_reg + {{13{voltage_sample[15]}}, voltage_sample};
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_SQ_II;
                    end
                    else if (frame_end)
                    begin
                        state_next = S_NS_GO;
                    end
                end
            end
            S_SQ_II:
            begin
                sii_next   = sii_reg + {12'd0, sm_p[30:0]};
                state_next = S_SQ_VV;
            end
            S_SQ_VV:
            begin
                svv_next   = svv_reg + {12'd0, sm_p[30:0]};
                state_next = S_SQ_IV;
            end
            S_SQ_IV:
            begin
                siv_next   = siv_reg + {{12{sm_p[31]}}, sm_p};
                state_next = fe_reg ? S_NS_GO : S_IDLE;
            end
            S_NS_GO:
            begin
                mul_start  = 1'b1;
                mul_a      = {{(MUL_W - IDX_W){1'b0}}, idx_reg};
                mul_b      = {21'd0, sq_sel};
                state_next = S_NS_W;
            end
            S_NS_W:
            begin
                mul_a = {36'd0, sum_abs_sel};
                mul_b = {36'd0, sum_abs_sel};
                if (mul_done)
                begin
                    ns_next    = mul_p[55:0];
                    mul_start  = 1'b1;
                    state_next = S_S2_W;
                end
            end
            S_S2_W:
            begin
                if (mul_done)
                begin
                    s2_next    = mul_p[55:0];
                    state_next = S_RT_GO;
                end
            end
            S_RT_GO:
            begin
                sqrt_start = 1'b1;
                state_next = S_RT_W;
            end
            S_RT_W:
            begin
                mul_a = {36'd0, sqrt_root};
                mul_b = {32'd0, scale_sel};
                if (sqrt_done)
                begin
                    mul_start  = 1'b1;
                    state_next = S_RN_W;
                end
            end
            S_RN_W:
            begin
                div_num = mul_p[DIV_NUM_W-1:0];
                div_den = {27'd0, n_adc};
                if (mul_done)
                begin
                    div_start  = 1'b1;
                    state_next = S_RD_W;
                end
            end
            S_RD_W:
            begin
                if (div_done)
                begin
                    if (!ch_reg)
                    begin
                        irms_next  = rms_val;
                        ch_next    = 1'b1;
                        state_next = S_NS_GO;
                    end
                    else
                    begin
                        vrms_next  = rms_val;
                        state_next = S_PA_GO;
                    end
                end
            end
            S_PA_GO:
            begin
                mul_start  = 1'b1;
                mul_a      = {{(MUL_W - IDX_W){1'b0}}, idx_reg};
                mul_b      = {21'd0, siv_abs};
                state_next = S_PA_W;
            end
            S_PA_W:
            begin
                mul_a = {36'd0, si_abs};
                mul_b = {36'd0, sv_abs};
                if (mul_done)
                begin
                    pa_next    = mul_p[55:0];
                    mul_start  = 1'b1;
                    state_next = S_PB_W;
                end
            end
            S_PB_W:
            begin
                mul_a = {32'd0, cscale_reg};
                mul_b = {32'd0, vscale_reg};
                if (mul_done)
                begin
                    pb_next    = mul_p[55:0];
                    mul_start  = 1'b1;
                    state_next = S_PC_W;
                end
            end
            S_PC_W:
            begin
                mul_a = {36'd0, n_adc};
                mul_b = {36'd0, n_adc};
                if (mul_done)
                begin
                    cv_next    = mul_p[63:0];
                    mul_start  = 1'b1;
                    state_next = S_PD_W;
                end
            end
            S_PD_W:
            begin
                mul_a = {4'd0, e_abs};
                mul_b = cv_reg;
                if (mul_done)
                begin
                    nd_next    = mul_p[54:0];
                    mul_start  = 1'b1;
                    state_next = S_PP_W;
                end
            end
            S_PP_W:
            begin
                div_num = mul_p[127:32];
                div_den = nd_reg;
                if (mul_done)
                begin
                    div_start  = 1'b1;
                    state_next = S_PQ_W;
                end
            end
            S_PQ_W:
            begin
                mul_a = {16'd0, mag_val};
                mul_b = {48'd0, frac_reg};
                if (div_done)
                begin
                    mag_next   = mag_val;
                    neg_next   = e_neg;
                    mul_start  = 1'b1;
                    state_next = S_TH_W;
                end
            end
            S_TH_W:
            begin
                if (mul_done)
                begin
                    stable_next = {16'd0, rms_diff} < thr_eff;
                    state_next  = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    out_irms_next   = irms_reg;
                    out_vrms_next   = vrms_reg;
                    out_pw_next     = neg_reg ? (48'd0 - mag_reg) : mag_reg;
                    out_stable_next = stable_reg;
                    prev_rms_next   = irms_reg;
                    si_next         = '0;
                    sv_next         = '0;
                    sii_next        = '0;
                    svv_next        = '0;
                    siv_next        = '0;
                    idx_next        = '0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ch_reg        <= 1'b0;
            fe_reg        <= 1'b0;
            window_reg    <= IDX_W'(4000);
            cscale_reg    <= 32'd65536;
            vscale_reg    <= 32'd65536;
            frac_reg      <= 16'd655;
            floor_reg     <= 32'd131;
            si_reg        <= '0;
            sv_reg        <= '0;
            sii_reg       <= '0;
            svv_reg       <= '0;
            siv_reg       <= '0;
            idx_reg       <= '0;
            prev_rms_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ch_reg        <= ch_next;
            fe_reg        <= fe_next;
            window_reg    <= window_next;
            cscale_reg    <= cscale_next;
            vscale_reg    <= vscale_next;
            frac_reg      <= frac_next;
            floor_reg     <= floor_next;
            si_reg        <= si_next;
            sv_reg        <= sv_next;
            sii_reg       <= sii_next;
            svv_reg       <= svv_next;
            siv_reg       <= siv_next;
            idx_reg       <= idx_next;
            prev_rms_reg  <= prev_rms_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ci_reg         <= ci_next;
        vi_reg         <= vi_next;
        ns_reg         <= ns_next;
        s2_reg         <= s2_next;
        irms_reg       <= irms_next;
        vrms_reg       <= vrms_next;
        pa_reg         <= pa_next;
        pb_reg         <= pb_next;
        cv_reg         <= cv_next;
        nd_reg         <= nd_next;
        mag_reg        <= mag_next;
        neg_reg        <= neg_next;
        stable_reg     <= stable_next;
        out_irms_reg   <= out_irms_next;
        out_vrms_reg   <= out_vrms_next;
        out_pw_reg     <= out_pw_next;
        out_stable_reg <= out_stable_next;
    end

    assign out_valid    = out_valid_reg;
    assign current_rms  = out_irms_reg;
    assign voltage_rms  = out_vrms_reg;
    assign active_power = out_pw_reg;
    assign stable       = out_stable_reg;

    `ASSERT_ALWAYS(a_idx_range, idx_reg <= MAX_WIN_N)
    `ASSERT_IMPLIES(a_div_den_nonzero, div_start, div_den != '0)
    `ASSERT_NEXT(a_frame_clear, state_reg == S_EMIT && state_next == S_IDLE, idx_reg == '0 && si_reg == '0 && siv_reg == '0 && prev_rms_reg == current_rms)
    `ASSERT_NEXT(a_emit_result, state_reg == S_EMIT && state_next == S_IDLE, out_valid_reg && stable == $past(stable_reg))
endmodule

// ===== src/rpm_mul.sv =====
// Shift-add unsigned multiplier, one bit of b per cycle
module rpm_mul (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [rpm_pkg::MUL_W-1:0]     a,
    input  logic [rpm_pkg::MUL_W-1:0]     b,
    output logic                          done,
    output logic [2*rpm_pkg::MUL_W-1:0]   p
);
    import rpm_pkg::*;

    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [$clog2(MUL_W)-1:0]   cnt_reg, cnt_next;
    logic [MUL_W-1:0]           a_reg, a_next;
    logic [MUL_W-1:0]           hi_reg, hi_next;
    logic [MUL_W-1:0]           lo_reg, lo_next;
    logic [MUL_W:0]             sum;

    assign sum = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, a_reg} : '0);

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        hi_next   = hi_reg;
        lo_next   = lo_reg;
        if (start && !busy_reg)
        begin
            busy_next = 1'b1;
            cnt_next  = '1;
            a_next    = a;
            hi_next   = '0;
            lo_next   = b;
        end
        else if (busy_reg)
        begin
            hi_next  = sum[MUL_W:1];
            lo_next  = {sum[0], lo_reg[MUL_W-1:1]};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            a_reg    <= '0;
            hi_reg   <= '0;
            lo_reg   <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            a_reg    <= a_next;
            hi_reg   <= hi_next;
            lo_reg   <= lo_next;
        end
    end

    assign done = done_reg;
    assign p    = {hi_reg, lo_reg};
endmodule

// ===== src/rpm_div.sv =====
// Restoring divider, one quotient bit per cycle, with overflow flag
module rpm_div (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [rpm_pkg::DIV_NUM_W-1:0]   num,
    input  logic [rpm_pkg::DIV_DEN_W-1:0]   den,
    output logic                            done,
    output logic [rpm_pkg::DIV_Q_W-1:0]     q,
    output logic                            ovf
);
    import rpm_pkg::*;

    localparam int HI_W = DIV_NUM_W - DIV_Q_W;

    logic                         busy_reg, busy_next;
    logic                         done_reg, done_next;
    logic [$clog2(DIV_Q_W)-1:0]   cnt_reg, cnt_next;
    logic [DIV_DEN_W-1:0]         den_reg, den_next;
    logic [DIV_DEN_W-1:0]         rem_reg, rem_next;
    logic [DIV_Q_W-1:0]           quo_reg, quo_next;
    logic                         ovf_reg, ovf_next;
    logic [DIV_DEN_W:0]           r2;
    logic [DIV_DEN_W:0]           r2_sub;
    logic                         ge;

    assign r2     = {rem_reg, quo_reg[DIV_Q_W-1]};
    assign r2_sub = r2 - {1'b0, den_reg};
    assign ge     = r2 >= {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        ovf_next  = ovf_reg;
        if (start && !busy_reg)
        begin
            busy_next = 1'b1;
            cnt_next  = $clog2(DIV_Q_W)'(DIV_Q_W - 1);
            den_next  = den;
            rem_next  = DIV_DEN_W'(num[DIV_NUM_W-1:DIV_Q_W]);
            quo_next  = num[DIV_Q_W-1:0];
            ovf_next  = {{(DIV_DEN_W + 1 - HI_W){1'b0}}, num[DIV_NUM_W-1:DIV_Q_W]}
                        >= {1'b0, den};
        end
        else if (busy_reg)
        begin
            rem_next = ge ? r2_sub[DIV_DEN_W-1:0] : r2[DIV_DEN_W-1:0];
            quo_next = {quo_reg[DIV_Q_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            den_reg  <= '0;
            rem_reg  <= '0;
            quo_reg  <= '0;
            ovf_reg  <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            den_reg  <= den_next;
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
            ovf_reg  <= ovf_next;
        end
    end

    assign done = done_reg;
    assign q    = quo_reg;
    assign ovf  = ovf_reg;
endmodule

// ===== src/rpm_sqrt.sv =====
// Digit-by-digit integer square root, one result bit per cycle
module rpm_sqrt (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [rpm_pkg::SQRT_IN_W-1:0]     x,
    output logic                              done,
    output logic [rpm_pkg::SQRT_OUT_W-1:0]    root
);
    import rpm_pkg::*;

    logic                            busy_reg, busy_next;
    logic                            done_reg, done_next;
    logic [$clog2(SQRT_OUT_W)-1:0]   cnt_reg, cnt_next;
    logic [SQRT_IN_W-1:0]            v_reg, v_next;
    logic [SQRT_IN_W-1:0]            res_reg, res_next;
    logic [SQRT_IN_W-1:0]            bit_reg, bit_next;
    logic [SQRT_IN_W:0]              trial;
    logic                            ge;

    assign trial = {1'b0, res_reg} + {1'b0, bit_reg};
    assign ge    = {1'b0, v_reg} >= trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        v_next    = v_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        if (start && !busy_reg)
        begin
            busy_next = 1'b1;
            cnt_next  = $clog2(SQRT_OUT_W)'(SQRT_OUT_W - 1);
            v_next    = x;
            res_next  = '0;
            bit_next  = {2'b01, {(SQRT_IN_W - 2){1'b0}}};
        end
        else if (busy_reg)
        begin
            if (ge)
            begin
                v_next   = v_reg - trial[SQRT_IN_W-1:0];
                res_next = (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            v_reg    <= '0;
            res_reg  <= '0;
            bit_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            v_reg    <= v_next;
            res_reg  <= res_next;
            bit_reg  <= bit_next;
        end
    end

    assign done = done_reg;
    assign root = res_reg[SQRT_OUT_W-1:0];
endmodule

// ===== tb/rpm_checker.sv =====
// Checker for the RMS power meter: tracks sums, predicts each frame reading, compares outputs
module rpm_checker
    import rpm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic signed [15:0] current_sample,
    input  logic signed [15:0] voltage_sample,
    input  logic               frame_end,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic [31:0]        current_rms,
    input  logic [31:0]        voltage_rms,
    input  logic signed [47:0] active_power,
    input  logic               stable,
    input  logic               cfg_write,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    output int                 errors,
    output int                 pending
);

    typedef struct packed {
        logic [31:0] irms;
        logic [31:0] vrms;
        logic [47:0] power;
        logic        stable;
    } reading_t;

    reading_t expected_readings[$];

    logic [12:0]        win_reg;
    logic [31:0]        cur_scale;
    logic [31:0]        vol_scale;
    logic [15:0]        fraction;
    logic [31:0]        floor_amps;
    logic signed [63:0] sum_i;
    logic signed [63:0] sum_v;
    logic signed [63:0] sum_iv;
    logic [63:0]        sum_ii;
    logic [63:0]        sum_vv;
    logic [63:0]        taken;
    logic [31:0]        last_irms;

    assign pending = expected_readings.size();

    function automatic logic [63:0] int_root(input logic [63:0] x);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0)
        begin
            if (x >= res + b)
            begin
                x = x - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic logic [31:0] ac_rms(input logic [63:0] n, input logic signed [63:0] s,
                                           input logic [63:0] sq, input logic [31:0] scale);
        logic [127:0] a;
        logic [127:0] ns;
        logic [127:0] d;
        logic [127:0] q;
        a = (s < 0) ? 128'(-s) : 128'(s);
        ns = 128'(n) * 128'(sq);
        d = (ns > a * a) ? ns - a * a : 128'd0;
        q = 128'(int_root(d[63:0])) * 128'(scale) / (128'(n) * 128'd32767);
        return (q > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
    endfunction

    function automatic reading_t predict_frame();
        reading_t r;
        logic signed [127:0] e;
        logic [127:0] m;
        logic [127:0] x;
        logic [127:0] den;
        logic [127:0] q;
        logic [127:0] thr;
        logic [31:0]  diff;
        logic         neg;
        r.irms = ac_rms(taken, sum_i, sum_ii, cur_scale);
        r.vrms = ac_rms(taken, sum_v, sum_vv, vol_scale);
        e = 128'(signed'(taken)) * 128'(sum_iv) - 128'(sum_i) * 128'(sum_v);
        neg = e < 0;
        m = neg ? 128'(-e) : 128'(e);
        x = (m * 128'(cur_scale) * 128'(vol_scale)) >> 32;
        den = 128'(taken) * 128'(taken) * 128'd32767 * 128'd32767;
        q = x / den;
        if (neg && q > 128'(POW_NEG_MAX))
            q = 128'(POW_NEG_MAX);
        if (!neg && q > 128'(POW_POS_MAX))
            q = 128'(POW_POS_MAX);
        r.power = neg ? 48'(-q) : q[47:0];
        thr = (q * 128'(fraction)) >> 16;
        if (thr < 128'(floor_amps))
            thr = 128'(floor_amps);
        diff = (last_irms > r.irms) ? last_irms - r.irms : r.irms - last_irms;
        r.stable = 128'(diff) < thr;
        return r;
    endfunction

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("MISMATCH %0t: %s got %0h expected %0h", $realtime, what, got, want);
        errors++;
    endtask

    initial errors = 0;

    always @(posedge clk or negedge rst_n)
    begin
        reading_t r;
        reading_t w;
        logic [12:0] win;
        if (!rst_n)
        begin
            win_reg = 13'd4000;
            cur_scale = 32'd65536;
            vol_scale = 32'd65536;
            fraction = 16'd655;
            floor_amps = 32'd131;
            sum_i = 0;
            sum_v = 0;
            sum_iv = 0;
            sum_ii = 0;
            sum_vv = 0;
            taken = 0;
            last_irms = 0;
            expected_readings.delete();
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_WINDOW:    win_reg = cfg_data[12:0];
                    REG_CUR_SCALE: cur_scale = cfg_data;
                    REG_VOL_SCALE: vol_scale = cfg_data;
                    REG_FRACTION:  fraction = cfg_data[15:0];
                    REG_FLOOR:     floor_amps = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                win = (win_reg == 0) ? 13'd1 : (win_reg > MAX_WINDOW) ? 13'(MAX_WINDOW) : win_reg;
                if (taken < 64'(win))
                begin
                    sum_i += 64'(current_sample);
                    sum_v += 64'(voltage_sample);
                    sum_ii += 64'(64'(current_sample) * 64'(current_sample));
                    sum_vv += 64'(64'(voltage_sample) * 64'(voltage_sample));
                    sum_iv += 64'(current_sample) * 64'(voltage_sample);
                    taken++;
                end
                if (frame_end)
                begin
                    r = predict_frame();
                    expected_readings.push_back(r);
                    last_irms = r.irms;
                    sum_i = 0;
                    sum_v = 0;
                    sum_iv = 0;
                    sum_ii = 0;
                    sum_vv = 0;
                    taken = 0;
                end
            end
            if (out_valid && !out_stall)
            begin
                if (expected_readings.size() == 0)
                    report("unexpected transfer", 64'(current_rms), 0);
                else
                begin
                    w = expected_readings.pop_front();
                    if (current_rms !== w.irms)
                        report("current_rms", 64'(current_rms), 64'(w.irms));
                    if (voltage_rms !== w.vrms)
                        report("voltage_rms", 64'(voltage_rms), 64'(w.vrms));
                    if (active_power !== w.power)
                        report("active_power", 64'(active_power), 64'(w.power));
                    if (stable !== w.stable)
                        report("stable", 64'(stable), 64'(w.stable));
                end
            end
        end
    end

endmodule

// ===== tb/tb_top.sv =====
// Top of the RMS power meter testbench: stimulus, stall control and verdict
module tb_top;
    import rpm_pkg::*;

    localparam int ITEM_TARGET = 1750;
    localparam int QUIET_FROM  = 1500;
    localparam int IDLE_LIMIT  = 20000;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic signed [15:0] current_sample;
    logic signed [15:0] voltage_sample;
    logic               frame_end;
    logic               out_valid;
    logic               out_stall;
    logic [31:0]        current_rms;
    logic [31:0]        voltage_rms;
    logic signed [47:0] active_power;
    logic               stable;
    logic               cfg_write;
    logic [2:0]         cfg_index;
    logic [31:0]        cfg_data;
    int                 errors;
    int                 pending;
    int                 sent;
    int                 idle_cycles;
    logic               quiet;
    logic               calm;

    rms_power_meter_with_stability u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .current_sample (current_sample),
        .voltage_sample (voltage_sample),
        .frame_end      (frame_end),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .current_rms    (current_rms),
        .voltage_rms    (voltage_rms),
        .active_power   (active_power),
        .stable         (stable),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    rpm_checker u_checker (.*);

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // receiver stalls in bursts
    initial
    begin
        int burst;
        out_stall = 0;
        forever
        begin
            @(negedge clk);
            if (!quiet && !calm && $urandom_range(0, 9) == 0)
            begin
                burst = $urandom_range(1, 18);
                out_stall <= 1;
                repeat (burst) @(negedge clk);
                out_stall <= 0;
            end
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        cfg_write <= 1;
        cfg_index <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_write <= 0;
        @(negedge clk);
    endtask

    // sender pauses until every reading is out and the pipeline has drained
    task automatic drain();
        in_valid <= 0;
        @(posedge clk);
        while (pending != 0 || in_stall) @(posedge clk);
        repeat (20) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_pair(input logic signed [15:0] c, input logic signed [15:0] v,
                             input logic last);
        int gap;
        if (!quiet && !calm && $urandom_range(0, 11) == 0)
        begin
            gap = $urandom_range(1, 18);
            in_valid <= 0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1;
        current_sample <= c;
        voltage_sample <= v;
        frame_end <= last;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sent++;
        @(negedge clk);
    endtask

    function automatic logic signed [15:0] pick(input int mode);
        case (mode)
            0: return 16'($urandom);
            1: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            2: return 16'($signed($urandom_range(0, 400)) - 200);
            default: return 16'($signed($urandom_range(0, 20000)) - 10000);
        endcase
    endfunction

    task automatic send_frame(input int len);
        int mode;
        int rel;
        logic signed [15:0] c;
        logic signed [15:0] v;
        mode = $urandom_range(0, 3);
        rel = $urandom_range(0, 3);
        for (int k = 0; k < len; k++)
        begin
            c = pick(mode);
            case (rel)
                0: v = c;
                1: v = -c;
                default: v = pick(mode);
            endcase
            send_pair(c, v, k == len - 1);
        end
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(0, 1 << 20);
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        logic [12:0] win;
        int cap;
        int frames;
        rst_n = 0;
        in_valid = 0;
        current_sample = 0;
        voltage_sample = 0;
        frame_end = 0;
        cfg_write = 0;
        cfg_index = REG_WINDOW;
        cfg_data = 0;
        quiet = 0;
        calm = 1;
        sent = 0;
        idle_cycles = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed: extremes at reset settings
        send_pair(16'sh7FFF, 16'sh7FFF, 0);
        send_pair(16'sh8000, 16'sh8000, 0);
        send_pair(16'sh8000, 16'sh7FFF, 0);
        send_pair(16'sh7FFF, 16'sh8000, 1);
        send_pair(16'sh8000, 16'sh8000, 1);
        send_pair(16'sd1000, -16'sd1000, 0);
        send_pair(16'sd1000, -16'sd1000, 1);
        drain();
        // saturated rms and power, widest threshold
        write_reg(REG_CUR_SCALE, 32'hFFFF_FFFF);
        write_reg(REG_VOL_SCALE, 32'hFFFF_FFFF);
        write_reg(REG_FRACTION, 32'hFFFF);
        write_reg(REG_FLOOR, 32'hFFFF_FFFF);
        send_pair(16'sh7FFF, 16'sh7FFF, 0);
        send_pair(16'sh8000, 16'sh8000, 1);
        send_pair(16'sh7FFF, 16'sh8000, 0);
        send_pair(16'sh8000, 16'sh7FFF, 1);
        drain();
        // zero window acts as one; frame longer than window
        write_reg(REG_WINDOW, 32'd0);
        write_reg(REG_FLOOR, 32'd0);
        write_reg(REG_FRACTION, 32'd0);
        send_pair(16'sd500, 16'sd300, 0);
        send_pair(-16'sd500, 16'sd300, 1);
        drain();
        // window lowered mid-frame
        write_reg(REG_WINDOW, 32'd4096);
        send_pair(16'sd1234, -16'sd77, 0);
        send_pair(-16'sd900, 16'sd4000, 0);
        send_pair(16'sd32000, 16'sd5, 0);
        drain();
        write_reg(REG_WINDOW, 32'd2);
        send_pair(16'sd7, 16'sd7, 0);
        send_pair(16'sd9, 16'sd9, 1);
        drain();

        while (sent < ITEM_TARGET)
        begin
            quiet = sent >= QUIET_FROM;
            calm = $urandom_range(0, 4) == 0;
            case ($urandom_range(0, 9))
                0: win = 13'd0;
                1: win = 13'd4096;
                2: win = 13'h1FFF;
                3: win = 13'($urandom);
                default: win = 13'($urandom_range(1, 24));
            endcase
            write_reg(REG_WINDOW, 32'(win));
            write_reg(REG_CUR_SCALE, pick_word());
            write_reg(REG_VOL_SCALE, pick_word());
            write_reg(REG_FRACTION,
                      $urandom_range(0, 3) == 0 ? 32'hFFFF : 32'($urandom_range(0, 2000)));
            write_reg(REG_FLOOR, pick_word() >> $urandom_range(0, 31));
            cap = (win == 0) ? 1 : (win > 24) ? 24 : int'(win);
            frames = $urandom_range(2, 8);
            for (int f = 0; f < frames; f++)
                send_frame($urandom_range(1, cap + 4));
            drain();
        end

        quiet = 1;
        drain();
        repeat (50) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
